[design/mhpq_pkg.sv]
package mhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int VIN_W    = 16;
  localparam int CNT_O_W  = 11;
  localparam int IN_TD_W  = 56;
  localparam int OUT_TD_W = 64;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_HEAPIFY = 3'd2,
    OP_INSERT  = 3'd3,
    OP_DELMIN  = 3'd4,
    OP_DECKEY  = 3'd5,
    OP_NOP6    = 3'd6,
    OP_NOP7    = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DEL_ROOT,
    S_DEL_LAST,
    S_SD_CHK,
    S_SD_L,
    S_SD_R,
    S_SD_DEC,
    S_SU_CHK,
    S_SU_P,
    S_DK_CHK
  } state_t;

endpackage

[design/mhpq_ram.sv]
module mhpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/min_heap_priority_queue_top.sv]
// Min-heap priority queue: one operation per input beat, one result beat per operation.
// Insert sifts the new entry up from the end; decrease-key scans the entries for the
// vertex, then sifts up as insert, or reports not-found on a miss; delete-min moves the
// last entry to the root and sifts it down; heapify sinks each inner node, last first.
// One operation in flight: the next beat is taken once the result beat has left.
// Reset (rst_n low, synchronous) empties the heap, RAM kept.
module min_heap_priority_queue_top #(
  parameter int CAPACITY     = 1024,
  parameter int VERTEX_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // opcode[2:0], vertex[18:3], key[50:19], zero pad
  input  logic [mhpq_pkg::IN_TD_W-1:0]       in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[1:0], out_vertex[17:2], out_key[49:18], entry_count[60:50], zero pad
  output logic [mhpq_pkg::OUT_TD_W-1:0]      out_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = mhpq_pkg::KEY_W;
  localparam int EW = VERTEX_WIDTH + KW;
  localparam int XW = AW + 2;

  function automatic logic key_lt(input logic [EW-1:0] a, input logic [EW-1:0] b);
    return $signed(a[KW-1:0]) < $signed(b[KW-1:0]);
  endfunction

  mhpq_pkg::state_t  state_r, state_nxt;
  mhpq_pkg::opcode_t op_r, op_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     hidx_r, hidx_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [EW-1:0]     cur_r, cur_nxt;
  logic [EW-1:0]     lch_r, lch_nxt;
  logic [EW-1:0]     rch_r, rch_nxt;
  logic              hasr_r, hasr_nxt;
  logic              out_valid_r;
  mhpq_pkg::status_t res_st_r;
  logic [mhpq_pkg::VIN_W-1:0]   res_vert_r, res_vert_nxt;
  logic [KW-1:0]                res_key_r, res_key_nxt;
  logic [mhpq_pkg::CNT_O_W-1:0] res_cnt_r;

  logic              fin;
  mhpq_pkg::status_t fin_st;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  mhpq_pkg::opcode_t in_op;
  logic [EW-1:0]     in_entry;
  logic              accept;
  logic [XW-1:0]     lidx, ridx, cnt_x;
  logic              l_ok, r_ok;
  logic [AW-1:0]     pidx;
  logic              lt_l, pick_r, pick_any;
  logic [CW-1:0]     half;

  mhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_op    = mhpq_pkg::opcode_t'(in_tdata[2:0]);
  assign in_entry = {VERTEX_WIDTH'(in_tdata[18:3]), in_tdata[50:19]};
  assign in_tready = (state_r == mhpq_pkg::S_IDLE) && !out_valid_r;
  assign accept   = in_tvalid && in_tready;

  assign lidx  = XW'({idx_r, 1'b1});
  assign ridx  = lidx + XW'(1);
  assign cnt_x = XW'(cnt_r);
  assign l_ok  = lidx < cnt_x;
  assign r_ok  = ridx < cnt_x;
  assign pidx  = (idx_r - AW'(1)) >> 1;
  assign half  = cnt_r >> 1;

  // shared compare unit for sift-down
  assign lt_l     = key_lt(lch_r, cur_r);
  assign pick_r   = hasr_r && key_lt(rch_r, lt_l ? lch_r : cur_r);
  assign pick_any = lt_l || pick_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            mhpq_pkg::OP_HEAPIFY: if (cnt_r > CW'(1)) state_nxt = mhpq_pkg::S_LOAD;
            mhpq_pkg::OP_INSERT:
              if (cnt_r != CW'(CAPACITY)) state_nxt = mhpq_pkg::S_SU_CHK;
            mhpq_pkg::OP_DELMIN: if (cnt_r != '0) state_nxt = mhpq_pkg::S_DEL_ROOT;
            mhpq_pkg::OP_DECKEY: if (cnt_r != '0) state_nxt = mhpq_pkg::S_DK_CHK;
            default: state_nxt = mhpq_pkg::S_IDLE;
          endcase
        end
      end
      mhpq_pkg::S_LOAD:     state_nxt = mhpq_pkg::S_SD_CHK;
      mhpq_pkg::S_DEL_ROOT:
        state_nxt = (cnt_r == CW'(1)) ? mhpq_pkg::S_IDLE : mhpq_pkg::S_DEL_LAST;
      mhpq_pkg::S_DEL_LAST: state_nxt = mhpq_pkg::S_SD_CHK;
      mhpq_pkg::S_SD_CHK: begin
        if (l_ok) begin
          state_nxt = mhpq_pkg::S_SD_L;
        end else if (op_r == mhpq_pkg::OP_HEAPIFY && hidx_r != '0) begin
          state_nxt = mhpq_pkg::S_LOAD;
        end else begin
          state_nxt = mhpq_pkg::S_IDLE;
        end
      end
      mhpq_pkg::S_SD_L: state_nxt = r_ok ? mhpq_pkg::S_SD_R : mhpq_pkg::S_SD_DEC;
      mhpq_pkg::S_SD_R: state_nxt = mhpq_pkg::S_SD_DEC;
      mhpq_pkg::S_SD_DEC: begin
        if (pick_any) begin
          state_nxt = mhpq_pkg::S_SD_CHK;
        end else if (op_r == mhpq_pkg::OP_HEAPIFY && hidx_r != '0) begin
          state_nxt = mhpq_pkg::S_LOAD;
        end else begin
          state_nxt = mhpq_pkg::S_IDLE;
        end
      end
      mhpq_pkg::S_SU_CHK: state_nxt = (idx_r == '0) ? mhpq_pkg::S_IDLE : mhpq_pkg::S_SU_P;
      mhpq_pkg::S_SU_P:
        state_nxt = key_lt(cur_r, ram_rdata) ? mhpq_pkg::S_SU_CHK : mhpq_pkg::S_IDLE;
      mhpq_pkg::S_DK_CHK: begin
        if (ram_rdata[EW-1:KW] == cur_r[EW-1:KW]) begin
          state_nxt = mhpq_pkg::S_SU_CHK;
        end else if (CW'(idx_r) == cnt_r - CW'(1)) begin
          state_nxt = mhpq_pkg::S_IDLE;
        end else begin
          state_nxt = mhpq_pkg::S_DK_CHK;
        end
      end
      default: state_nxt = mhpq_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    op_nxt       = op_r;
    cnt_nxt      = cnt_r;
    hidx_nxt     = hidx_r;
    idx_nxt      = idx_r;
    cur_nxt      = cur_r;
    lch_nxt      = lch_r;
    rch_nxt      = rch_r;
    hasr_nxt     = hasr_r;
    res_vert_nxt = res_vert_r;
    res_key_nxt  = res_key_r;
    fin          = 1'b0;
    fin_st       = mhpq_pkg::ST_OK;
    ram_we       = 1'b0;
    ram_waddr    = idx_r;
    ram_wdata    = cur_r;
    ram_raddr    = '0;
    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt       = in_op;
          cur_nxt      = in_entry;
          res_vert_nxt = '0;
          res_key_nxt  = '0;
          unique case (in_op)
            mhpq_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
              fin     = 1'b1;
            end
            mhpq_pkg::OP_APPEND: begin
              fin = 1'b1;
              if (cnt_r == CW'(CAPACITY)) begin
                fin_st = mhpq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_r);
                ram_wdata = in_entry;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            mhpq_pkg::OP_HEAPIFY: begin
              if (cnt_r > CW'(1)) begin
                hidx_nxt  = half - CW'(1);
                idx_nxt   = AW'(half - CW'(1));
                ram_raddr = AW'(half - CW'(1));
              end else begin
                fin = 1'b1;
              end
            end
            mhpq_pkg::OP_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                fin    = 1'b1;
                fin_st = mhpq_pkg::ST_FULL;
              end else begin
                idx_nxt = AW'(cnt_r);
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            mhpq_pkg::OP_DELMIN: begin
              if (cnt_r == '0) begin
                fin    = 1'b1;
                fin_st = mhpq_pkg::ST_EMPTY;
              end
            end
            mhpq_pkg::OP_DECKEY: begin
              idx_nxt = '0;
              if (cnt_r == '0) begin
                fin    = 1'b1;
                fin_st = mhpq_pkg::ST_NOTFOUND;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      mhpq_pkg::S_LOAD: cur_nxt = ram_rdata;
      mhpq_pkg::S_DEL_ROOT: begin
        res_vert_nxt = mhpq_pkg::VIN_W'(ram_rdata[EW-1:KW]);
        res_key_nxt  = ram_rdata[KW-1:0];
        cnt_nxt      = cnt_r - CW'(1);
        ram_raddr    = AW'(cnt_r - CW'(1));
        if (cnt_r == CW'(1)) fin = 1'b1;
      end
      mhpq_pkg::S_DEL_LAST: begin
        cur_nxt = ram_rdata;
        idx_nxt = '0;
      end
      mhpq_pkg::S_SD_CHK: begin
        if (l_ok) begin
          ram_raddr = AW'(lidx);
        end else begin
          ram_we = 1'b1;
          if (op_r == mhpq_pkg::OP_HEAPIFY && hidx_r != '0) begin
            hidx_nxt  = hidx_r - CW'(1);
            idx_nxt   = AW'(hidx_r - CW'(1));
            ram_raddr = AW'(hidx_r - CW'(1));
          end else begin
            fin = 1'b1;
          end
        end
      end
      mhpq_pkg::S_SD_L: begin
        lch_nxt   = ram_rdata;
        hasr_nxt  = r_ok;
        ram_raddr = AW'(ridx);
      end
      mhpq_pkg::S_SD_R: rch_nxt = ram_rdata;
      mhpq_pkg::S_SD_DEC: begin
        ram_we = 1'b1;
        if (pick_any) begin
          ram_wdata = pick_r ? rch_r : lch_r;
          idx_nxt   = pick_r ? AW'(ridx) : AW'(lidx);
        end else if (op_r == mhpq_pkg::OP_HEAPIFY && hidx_r != '0) begin
          hidx_nxt  = hidx_r - CW'(1);
          idx_nxt   = AW'(hidx_r - CW'(1));
          ram_raddr = AW'(hidx_r - CW'(1));
        end else begin
          fin = 1'b1;
        end
      end
      mhpq_pkg::S_SU_CHK: begin
        ram_raddr = pidx;
        if (idx_r == '0) begin
          ram_we = 1'b1;
          fin    = 1'b1;
        end
      end
      mhpq_pkg::S_SU_P: begin
        ram_we = 1'b1;
        if (key_lt(cur_r, ram_rdata)) begin
          ram_wdata = ram_rdata;  // parent moves down into the hole
          idx_nxt   = pidx;
        end else begin
          fin = 1'b1;
        end
      end
      mhpq_pkg::S_DK_CHK: begin
        // scan reads one entry per cycle; match found in the entry at idx_r
        if (ram_rdata[EW-1:KW] != cur_r[EW-1:KW]) begin
          if (CW'(idx_r) == cnt_r - CW'(1)) begin
            fin    = 1'b1;
            fin_st = mhpq_pkg::ST_NOTFOUND;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            ram_raddr = idx_r + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhpq_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      op_r        <= mhpq_pkg::OP_CLEAR;
      hidx_r      <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
      hidx_r  <= hidx_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cur_r      <= cur_nxt;
    lch_r      <= lch_nxt;
    rch_r      <= rch_nxt;
    hasr_r     <= hasr_nxt;
    res_vert_r <= res_vert_nxt;
    res_key_r  <= res_key_nxt;
    if (fin) begin
      res_st_r  <= fin_st;
      res_cnt_r <= mhpq_pkg::CNT_O_W'(cnt_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_cnt_r, res_key_r, res_vert_r, res_st_r};

endmodule

[tb/mhpq_checker.sv]
module mhpq_checker #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [mhpq_pkg::IN_TD_W-1:0]  in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [mhpq_pkg::OUT_TD_W-1:0] out_tdata,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0]        vert;
    logic signed [31:0] key;
  } entry_t;

  typedef struct packed {
    mhpq_pkg::status_t  status;
    logic [15:0]        vert;
    logic signed [31:0] key;
    logic [10:0]        count;
  } result_t;

  entry_t  heap_mem [CAPACITY];
  int      heap_size;
  result_t expected_q[$];

  function automatic void swap_at(int a, int b);
    entry_t t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic void sink(int i);
    int l, r, m;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < heap_size && heap_mem[l].key < heap_mem[m].key) m = l;
      if (r < heap_size && heap_mem[r].key < heap_mem[m].key) m = r;
      if (m == i) return;
      swap_at(i, m);
      i = m;
    end
  endfunction

  function automatic void rise(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(heap_mem[i].key < heap_mem[p].key)) return;
      swap_at(i, p);
      i = p;
    end
  endfunction

  function automatic result_t apply_op(mhpq_pkg::opcode_t op, logic [15:0] v,
                                       logic signed [31:0] k);
    result_t res;
    int      i;
    res = '0;
    res.status = mhpq_pkg::ST_OK;
    case (op)
      mhpq_pkg::OP_CLEAR: heap_size = 0;
      mhpq_pkg::OP_APPEND: begin
        if (heap_size >= CAPACITY) res.status = mhpq_pkg::ST_FULL;
        else begin
          heap_mem[heap_size] = '{vert: v, key: k};
          heap_size++;
        end
      end
      mhpq_pkg::OP_HEAPIFY: for (i = heap_size / 2; i > 0; i--) sink(i - 1);
      mhpq_pkg::OP_INSERT: begin
        if (heap_size >= CAPACITY) res.status = mhpq_pkg::ST_FULL;
        else begin
          i = heap_size;
          heap_size++;
          while (i > 0 && heap_mem[(i - 1) / 2].key > k) begin
            heap_mem[i] = heap_mem[(i - 1) / 2];
            i = (i - 1) / 2;
          end
          heap_mem[i] = '{vert: v, key: k};
        end
      end
      mhpq_pkg::OP_DELMIN: begin
        if (heap_size == 0) res.status = mhpq_pkg::ST_EMPTY;
        else begin
          res.vert = heap_mem[0].vert;
          res.key = heap_mem[0].key;
          heap_size--;
          heap_mem[0] = heap_mem[heap_size];
          sink(0);
        end
      end
      mhpq_pkg::OP_DECKEY: begin
        res.status = mhpq_pkg::ST_NOTFOUND;
        for (i = 0; i < heap_size; i++) begin
          if (heap_mem[i].vert == v) begin
            res.status = mhpq_pkg::ST_OK;
            heap_mem[i].key = k;
            rise(i);
            break;
          end
        end
      end
      default: ;
    endcase
    res.count = heap_size[10:0];
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t got, want;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      heap_size = 0;
      expected_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'({out_tdata[1:0], out_tdata[17:2], out_tdata[49:18], out_tdata[60:50]});
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %h", out_tdata);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
          if (got.vert !== want.vert) begin
            $error("out_vertex: expected %0d, got %0d", want.vert, got.vert);
            errs++;
          end
          if (got.key !== want.key) begin
            $error("out_key: expected %0d, got %0d", want.key, got.key);
            errs++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      // predicted after the pop so a same-cycle beat is never compared to itself
      if (in_tvalid && in_tready)
        expected_q.push_back(apply_op(mhpq_pkg::opcode_t'(in_tdata[2:0]), in_tdata[18:3],
                                      in_tdata[50:19]));
    end
  end
endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 1024;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [mhpq_pkg::IN_TD_W-1:0]  in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [mhpq_pkg::OUT_TD_W-1:0] out_tdata;
  int                  fail_count, pending, results_seen;
  int                  sent = 0;
  int                  live = 0;       // tb's own view of heap occupancy
  int                  vert_pool[$];   // vertices added since the last clear, for decrease-key hits

  always #1 clk = ~clk;

  min_heap_priority_queue_top #(.CAPACITY(CAP), .VERTEX_WIDTH(16)) DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata
  );

  mhpq_checker #(.CAPACITY(CAP)) checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending, .results_seen
  );

  // receiver stall pattern, with quiet stretches of no stalling
  always @(posedge clk) begin
    int phase;
    phase = int'(($time / 2000) % 4);
    if (phase == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 99) < 60);
  end

  task automatic send_op(mhpq_pkg::opcode_t op, logic [15:0] v, logic [31:0] k);
    in_tdata  <= {5'b0, k, v, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    case (op)
      mhpq_pkg::OP_CLEAR: begin live = 0; vert_pool.delete(); end
      mhpq_pkg::OP_APPEND, mhpq_pkg::OP_INSERT:
        if (live < CAP) begin live++; vert_pool.push_back(v); end
      mhpq_pkg::OP_DELMIN: if (live > 0) live--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_vert();
    if (vert_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return 16'(vert_pool[$urandom_range(0, vert_pool.size() - 1)]);
    return 16'($urandom);
  endfunction

  initial begin
    int r, burst;
    mhpq_pkg::opcode_t op;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, extremes, ties, larger key on decrease, unused opcodes
    send_op(mhpq_pkg::OP_DELMIN, 16'd0, 32'd0);
    send_op(mhpq_pkg::OP_DECKEY, 16'h1234, 32'd0);
    send_op(mhpq_pkg::OP_HEAPIFY, 16'd0, 32'd0);
    send_op(mhpq_pkg::OP_APPEND, 16'hffff, 32'h7fff_ffff);
    send_op(mhpq_pkg::OP_APPEND, 16'h0000, 32'h8000_0000);
    send_op(mhpq_pkg::OP_APPEND, 16'h5555, 32'd5);
    send_op(mhpq_pkg::OP_APPEND, 16'haaaa, 32'd5);
    send_op(mhpq_pkg::OP_DELMIN, 16'd0, 32'd0);            // unordered contents
    send_op(mhpq_pkg::OP_HEAPIFY, 16'd0, 32'd0);
    send_op(mhpq_pkg::OP_INSERT, 16'h0001, 32'd5);
    send_op(mhpq_pkg::OP_DECKEY, 16'hffff, 32'hffff_fffe);
    send_op(mhpq_pkg::OP_DECKEY, 16'h0001, 32'h7fff_ffff); // larger key stays put
    send_op(mhpq_pkg::OP_DECKEY, 16'hbeef, 32'd1);
    send_op(mhpq_pkg::OP_NOP6, 16'hffff, 32'hffff_ffff);
    send_op(mhpq_pkg::OP_NOP7, 16'd0, 32'd0);
    repeat (6) send_op(mhpq_pkg::OP_DELMIN, 16'd0, 32'd0);
    send_op(mhpq_pkg::OP_CLEAR, 16'd0, 32'd0);

    // random: mostly inserts and delete-mins on small heaps, some append/heapify runs
    while (sent < 600) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 2) op = mhpq_pkg::OP_CLEAR;
        else if (r < 14) op = mhpq_pkg::OP_APPEND;
        else if (r < 19) op = mhpq_pkg::OP_HEAPIFY;
        else if (r < 50) op = mhpq_pkg::OP_INSERT;
        else if (r < 80) op = mhpq_pkg::OP_DELMIN;
        else if (r < 97) op = mhpq_pkg::OP_DECKEY;
        else op = mhpq_pkg::opcode_t'($urandom_range(6, 7));
        if (live > 40 && (op == mhpq_pkg::OP_INSERT || op == mhpq_pkg::OP_APPEND))
          op = mhpq_pkg::OP_DELMIN;
        send_op(op, pick_vert(), rand_key());
      end
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("tb: %0d operations sent, %0d results checked, incl. empty, miss and tie cases",
             sent, results_seen);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

[sim.f]
design/mhpq_pkg.sv
design/mhpq_ram.sv
design/min_heap_priority_queue_top.sv
tb/mhpq_checker.sv
tb/tb.sv
